FILE: sv/arst_pkg.sv
// Shared types and constants for the affine range update / range sum tree.
// Used by the controller, the datapath, the multiplier and the top level.
// Depends on nothing.
package arst_pkg;

  localparam int unsigned MAX_LEN_DEF    = 1024;
  localparam int unsigned TREE_NODES_DEF = 4096;

  localparam int unsigned IDX_W   = 10;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned HALF_W  = DATA_W / 2;
  localparam int unsigned TDATA_W = 152;
  localparam int unsigned OUT_W   = 64;

  // Walk stack of the tree traversal.
  localparam int unsigned STACK_DEPTH = 24;
  localparam int unsigned STK_IW      = $clog2(STACK_DEPTH);
  localparam int unsigned SP_W        = $clog2(STACK_DEPTH + 1);

  // Operation codes carried in tuser.
  localparam logic FUNC_QUERY  = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  typedef enum logic [1:0] {ADDR_CUR, ADDR_LEFT, ADDR_RIGHT, ADDR_CLEAR} addr_sel_t;
  typedef enum logic [1:0] {LATCH_NONE, LATCH_CUR, LATCH_WORK, LATCH_LSUM} latch_sel_t;
  typedef enum logic [1:0] {LEN_NODE, LEN_LCHILD, LEN_RCHILD} len_sel_t;
  typedef enum logic [1:0] {MSEL_SUM, MSEL_LEN, MSEL_PMUL, MSEL_PADD} mul_sel_t;
  typedef enum logic [1:0] {WR_WORK, WR_IDENT, WR_PHASE, WR_CLEAR} wr_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_item;
    logic       clr_restart;
    logic       clr_step;
    logic       pop;
    logic       rd_en;
    addr_sel_t  addr_sel;
    latch_sel_t latch;
    logic       map_par;
    logic       map_item;
    logic       len_load;
    len_sel_t   len_sel;
    logic       mul_start;
    logic       mul_store;
    mul_sel_t   mul_sel;
    logic       wr_en;
    wr_kind_t   wr_kind;
    logic       push_children;
    logic       acc_add;
    logic       out_load;
  } arst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic stack_empty;
    logic node_bad;
    logic phase;
    logic has_children;
    logic child_ok;
    logic par_identity;
    logic disjoint;
    logic covered;
    logic is_update;
    logic room;
    logic mul_done;
    logic clr_last;
  } arst_status_t;

endpackage

FILE: sv/arst_mul64.sv
// Iterative 64 x 64 multiplier giving the low 64 bits of the product.
// Three 32 x 32 partial products are formed in turn; done pulses with the result.
// Depends on arst_pkg.
module arst_mul64
  import arst_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  output logic [DATA_W-1:0] p,
  output logic              done
);

  logic              busy;
  logic [1:0]        step;
  logic [DATA_W-1:0] a_r;
  logic [DATA_W-1:0] b_r;
  logic [DATA_W-1:0] prod;
  logic [DATA_W-1:0] acc;

  // Step control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial products: low x low, then the two cross terms shifted up by 32.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
    if (busy) begin
      case (step)
        2'd0: begin
          prod <= DATA_W'(a_r[HALF_W-1:0]) * DATA_W'(b_r[HALF_W-1:0]);
        end
        2'd1: begin
          acc  <= prod;
          prod <= DATA_W'(a_r[HALF_W-1:0]) * DATA_W'(b_r[DATA_W-1:HALF_W]);
        end
        2'd2: begin
          acc  <= acc + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
          prod <= DATA_W'(a_r[DATA_W-1:HALF_W]) * DATA_W'(b_r[HALF_W-1:0]);
        end
        default: begin
          acc <= acc + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
        end
      endcase
    end
  end

  assign p = acc;

endmodule

FILE: sv/arst_datapath.sv
// Datapath: node memory, walk stack, affine map registers, accumulator.
// Driven by arst_ctrl through arst_cmd_t; uses arst_mul64 and arst_pkg.
module arst_datapath
  import arst_pkg::*;
#(
  parameter int unsigned MAX_LEN    = MAX_LEN_DEF,
  parameter int unsigned TREE_NODES = TREE_NODES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  arst_cmd_t          cmd,
  output arst_status_t       status,
  input  logic               cfg_we,
  input  logic [LEN_W-1:0]   cfg_data,
  input  logic               in_func,
  input  logic [IDX_W-1:0]   in_left,
  input  logic [IDX_W-1:0]   in_right,
  input  logic [DATA_W-1:0]  in_mul,
  input  logic [DATA_W-1:0]  in_add,
  output logic [OUT_W-1:0]   out_data
);

  localparam int unsigned AW = $clog2(TREE_NODES);
  localparam int unsigned NW = AW + 1;
  localparam int unsigned EW = 3 * DATA_W;

  typedef struct packed {
    logic [NW-1:0]    node;
    logic             phase;
    logic [LEN_W-1:0] lo;
    logic [LEN_W-1:0] hi;
  } stk_entry_t;

  // Node memory: {sum, pending mul, pending add} per node.
  logic [EW-1:0] node_mem [TREE_NODES];
  logic [EW-1:0] rd_q;
  logic [AW-1:0] mem_addr;
  logic [EW-1:0] wdata;

  stk_entry_t       stack [STACK_DEPTH];
  logic [SP_W-1:0]  sp;
  stk_entry_t       cur;

  logic [LEN_W-1:0]  length;
  logic [AW-1:0]     clr_cnt;
  logic              item_upd;
  logic [IDX_W-1:0]  ql;
  logic [IDX_W-1:0]  qr;
  logic [DATA_W-1:0] item_m;
  logic [DATA_W-1:0] item_a;
  logic [DATA_W-1:0] cur_sum;
  logic [DATA_W-1:0] cur_pm;
  logic [DATA_W-1:0] cur_pa;
  logic [DATA_W-1:0] work_sum;
  logic [DATA_W-1:0] work_pm;
  logic [DATA_W-1:0] work_pa;
  logic [DATA_W-1:0] lsum;
  logic [DATA_W-1:0] map_m;
  logic [DATA_W-1:0] map_a;
  logic [DATA_W-1:0] tmp;
  logic [DATA_W-1:0] acc;
  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  len_next;

  logic [LEN_W-1:0]  mid;
  logic [NW-1:0]     child_l;
  logic [NW-1:0]     child_r;
  logic [LEN_W-1:0]  ql_x;
  logic [LEN_W-1:0]  qr_x;
  logic [STK_IW-1:0] p0;
  logic [STK_IW-1:0] p1;
  logic [STK_IW-1:0] p2;
  logic [STK_IW-1:0] top_idx;
  logic [LEN_W-1:0]  cfg_clamped;

  logic [DATA_W-1:0] mul_a;
  logic [DATA_W-1:0] mul_b;
  logic [DATA_W-1:0] mul_p;
  logic              mul_done;

  // Node geometry of the current walk entry.
  always_comb begin
    mid     = LEN_W'(({1'b0, cur.lo} + {1'b0, cur.hi}) >> 1);
    child_l = {cur.node[NW-2:0], 1'b0};
    child_r = {cur.node[NW-2:0], 1'b1};
    ql_x    = {{(LEN_W-IDX_W){1'b0}}, ql};
    qr_x    = {{(LEN_W-IDX_W){1'b0}}, qr};
    p0      = sp[STK_IW-1:0];
    p1      = p0 + STK_IW'(1);
    p2      = p0 + STK_IW'(2);
    top_idx = p0 - STK_IW'(1);
  end

  // Status back to the controller.
  always_comb begin
    status.stack_empty  = (sp == '0);
    status.node_bad     = (cur.node == '0) || (cur.node >= NW'(TREE_NODES));
    status.phase        = cur.phase;
    status.child_ok     = (child_r < NW'(TREE_NODES));
    status.has_children = (cur.lo < cur.hi) && status.child_ok;
    status.par_identity = (cur_pm == DATA_W'(1)) && (cur_pa == '0);
    status.disjoint     = (qr_x < cur.lo) || (ql_x > cur.hi);
    status.covered      = (ql_x <= cur.lo) && (cur.hi <= qr_x);
    status.is_update    = item_upd;
    status.room         = ({1'b0, sp} + (SP_W+1)'(3)) <= (SP_W+1)'(STACK_DEPTH);
    status.mul_done     = mul_done;
    status.clr_last     = (clr_cnt == AW'(TREE_NODES - 1));
  end

  // Memory address and write data.
  always_comb begin
    case (cmd.addr_sel)
      ADDR_CUR:   mem_addr = cur.node[AW-1:0];
      ADDR_LEFT:  mem_addr = child_l[AW-1:0];
      ADDR_RIGHT: mem_addr = child_r[AW-1:0];
      default:    mem_addr = clr_cnt;
    endcase
    case (cmd.wr_kind)
      WR_WORK:  wdata = {work_sum, work_pm, work_pa};
      WR_IDENT: wdata = {cur_sum, DATA_W'(1), {DATA_W{1'b0}}};
      WR_PHASE: wdata = {lsum + work_sum, cur_pm, cur_pa};
      default:  wdata = {{DATA_W{1'b0}}, DATA_W'(1), {DATA_W{1'b0}}};
    endcase
  end

  // Single-port node memory with registered read data.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      node_mem[mem_addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rd_q <= node_mem[mem_addr];
    end
  end

  // Length register clamped to 1 .. MAX_LEN, and the clearing counter.
  always_comb begin
    if (cfg_data == '0) begin
      cfg_clamped = LEN_W'(1);
    end else if (32'(cfg_data) > MAX_LEN) begin
      cfg_clamped = LEN_W'(MAX_LEN);
    end else begin
      cfg_clamped = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length  <= LEN_W'(MAX_LEN);
      clr_cnt <= '0;
      sp      <= '0;
    end else begin
      if (cfg_we) begin
        length <= cfg_clamped;
      end
      if (cmd.clr_restart) begin
        clr_cnt <= '0;
      end else if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (cmd.load_item) begin
        sp <= SP_W'(1);
      end else if (cmd.pop) begin
        sp <= sp - SP_W'(1);
      end else if (cmd.push_children) begin
        sp <= item_upd ? sp + SP_W'(3) : sp + SP_W'(2);
      end
    end
  end

  // Walk stack contents: the root on load, children (and a recombine mark) on push.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      stack[0] <= '{node: NW'(1), phase: 1'b0, lo: '0, hi: length - LEN_W'(1)};
    end else if (cmd.push_children) begin
      if (item_upd) begin
        stack[p0] <= '{node: cur.node, phase: 1'b1, lo: cur.lo, hi: cur.hi};
        stack[p1] <= '{node: child_r, phase: 1'b0, lo: mid + LEN_W'(1), hi: cur.hi};
        stack[p2] <= '{node: child_l, phase: 1'b0, lo: cur.lo, hi: mid};
      end else begin
        stack[p0] <= '{node: child_r, phase: 1'b0, lo: mid + LEN_W'(1), hi: cur.hi};
        stack[p1] <= '{node: child_l, phase: 1'b0, lo: cur.lo, hi: mid};
      end
    end
  end

  // Element count of the node or child that a map is applied to.
  always_comb begin
    case (cmd.len_sel)
      LEN_NODE:   len_next = cur.hi - cur.lo + LEN_W'(1);
      LEN_LCHILD: len_next = mid - cur.lo + LEN_W'(1);
      LEN_RCHILD: len_next = cur.hi - mid;
      default:    len_next = '0;
    endcase
  end

  // Multiplier operands.
  always_comb begin
    case (cmd.mul_sel)
      MSEL_SUM:  begin mul_a = map_m; mul_b = work_sum; end
      MSEL_LEN:  begin mul_a = map_a; mul_b = {{(DATA_W-LEN_W){1'b0}}, len_r}; end
      MSEL_PMUL: begin mul_a = map_m; mul_b = work_pm; end
      default:   begin mul_a = map_m; mul_b = work_pa; end
    endcase
  end

  arst_mul64 u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .p     (mul_p),
    .done  (mul_done)
  );

  // Item capture, entry registers, affine map evaluation and accumulation.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_upd <= (in_func == FUNC_UPDATE);
      ql       <= in_left;
      qr       <= in_right;
      item_m   <= in_mul;
      item_a   <= in_add;
      acc      <= '0;
    end
    if (cmd.pop) begin
      cur <= stack[top_idx];
    end
    case (cmd.latch)
      LATCH_CUR:  {cur_sum, cur_pm, cur_pa} <= rd_q;
      LATCH_WORK: {work_sum, work_pm, work_pa} <= rd_q;
      LATCH_LSUM: lsum <= rd_q[EW-1 -: DATA_W];
      default: ;
    endcase
    if (cmd.map_par) begin
      map_m <= cur_pm;
      map_a <= cur_pa;
    end else if (cmd.map_item) begin
      map_m <= item_m;
      map_a <= item_a;
    end
    if (cmd.len_load) begin
      len_r <= len_next;
    end
    if (cmd.mul_store && mul_done) begin
      case (cmd.mul_sel)
        MSEL_SUM:  tmp      <= mul_p;
        MSEL_LEN:  work_sum <= tmp + mul_p;
        MSEL_PMUL: work_pm  <= mul_p;
        default:   work_pa  <= mul_p + map_a;
      endcase
    end
    if (cmd.acc_add) begin
      acc <= acc + cur_sum;
    end
    if (cmd.out_load) begin
      out_data <= acc;
    end
  end

endmodule

FILE: sv/arst_ctrl.sv
// Controller state machine for the tree walk, map push-down and clearing pass.
// Issues arst_cmd_t to the datapath and reads arst_status_t; uses arst_pkg.
module arst_ctrl
  import arst_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_fire,
  input  logic         in_fire,
  input  logic         out_ready,
  input  arst_status_t status,
  output arst_cmd_t    cmd,
  output logic         in_ready,
  output logic         out_valid
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_POP, S_DECODE,
    S_PH_RDC, S_PH_LC, S_PH_LL, S_PH_LR, S_PH_WR,
    S_RDC, S_LC, S_PD_CHK, S_RDL, S_LL, S_RDR, S_LR,
    S_AP_GO, S_AP_WT, S_AP_WR, S_WID, S_CLS, S_CRD, S_CLT, S_FINISH
  } state_t;

  typedef enum logic [1:0] {RET_LEFT, RET_RIGHT, RET_CUR} ret_t;

  state_t   state, state_next;
  mul_sel_t ap_sel, ap_sel_next;
  ret_t     ret, ret_next;
  logic     out_valid_next;

  // Next state and commands.
  always_comb begin
    state_next     = state;
    ap_sel_next    = ap_sel;
    ret_next       = ret;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.addr_sel   = ADDR_CUR;
    cmd.latch      = LATCH_NONE;
    cmd.len_sel    = LEN_NODE;
    cmd.mul_sel    = ap_sel;
    cmd.wr_kind    = WR_WORK;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        cmd.wr_en    = 1'b1;
        cmd.wr_kind  = WR_CLEAR;
        cmd.addr_sel = ADDR_CLEAR;
        if (status.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd.load_item = 1'b1;
          state_next    = S_POP;
        end
      end
      S_POP: begin
        if (status.stack_empty) begin
          state_next = status.is_update ? S_IDLE : S_FINISH;
        end else begin
          cmd.pop    = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.node_bad) state_next = S_POP;
        else if (status.phase) state_next = S_PH_RDC;
        else state_next = S_RDC;
      end
      // Recombine a node's sum from its two children.
      S_PH_RDC: begin
        cmd.rd_en  = 1'b1;
        state_next = S_PH_LC;
      end
      S_PH_LC: begin
        cmd.latch    = LATCH_CUR;
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = ADDR_LEFT;
        state_next   = S_PH_LL;
      end
      S_PH_LL: begin
        cmd.latch    = LATCH_LSUM;
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = ADDR_RIGHT;
        state_next   = S_PH_LR;
      end
      S_PH_LR: begin
        cmd.latch  = LATCH_WORK;
        state_next = S_PH_WR;
      end
      S_PH_WR: begin
        cmd.wr_en   = status.child_ok;
        cmd.wr_kind = WR_PHASE;
        state_next  = S_POP;
      end
      // Visit a node: read it, push its pending map to the children.
      S_RDC: begin
        cmd.rd_en  = 1'b1;
        state_next = S_LC;
      end
      S_LC: begin
        cmd.latch  = LATCH_CUR;
        state_next = S_PD_CHK;
      end
      S_PD_CHK: begin
        if (status.has_children && !status.par_identity) begin
          cmd.map_par = 1'b1;
          state_next  = S_RDL;
        end else begin
          state_next = S_CLS;
        end
      end
      S_RDL: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = ADDR_LEFT;
        cmd.len_load = 1'b1;
        cmd.len_sel  = LEN_LCHILD;
        state_next   = S_LL;
      end
      S_LL: begin
        cmd.latch   = LATCH_WORK;
        ap_sel_next = MSEL_SUM;
        ret_next    = RET_LEFT;
        state_next  = S_AP_GO;
      end
      S_RDR: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = ADDR_RIGHT;
        cmd.len_load = 1'b1;
        cmd.len_sel  = LEN_RCHILD;
        state_next   = S_LR;
      end
      S_LR: begin
        cmd.latch   = LATCH_WORK;
        ap_sel_next = MSEL_SUM;
        ret_next    = RET_RIGHT;
        state_next  = S_AP_GO;
      end
      // Apply map (m, a) to the work entry: four multiplies in turn.
      S_AP_GO: begin
        cmd.mul_start = 1'b1;
        state_next    = S_AP_WT;
      end
      S_AP_WT: begin
        cmd.mul_store = 1'b1;
        if (status.mul_done) begin
          if (ap_sel == MSEL_PADD) begin
            state_next = S_AP_WR;
          end else begin
            ap_sel_next = mul_sel_t'(ap_sel + 2'd1);
            state_next  = S_AP_GO;
          end
        end
      end
      S_AP_WR: begin
        cmd.wr_en = 1'b1;
        case (ret)
          RET_LEFT: begin
            cmd.addr_sel = ADDR_LEFT;
            state_next   = S_RDR;
          end
          RET_RIGHT: begin
            cmd.addr_sel = ADDR_RIGHT;
            state_next   = S_WID;
          end
          default: begin
            cmd.addr_sel = ADDR_CUR;
            state_next   = S_POP;
          end
        endcase
      end
      S_WID: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_kind = WR_IDENT;
        state_next  = S_CLS;
      end
      // Classify the node against the requested range.
      S_CLS: begin
        if (status.disjoint) begin
          state_next = S_POP;
        end else if (status.covered) begin
          if (status.is_update) begin
            state_next = S_CRD;
          end else begin
            cmd.acc_add = 1'b1;
            state_next  = S_POP;
          end
        end else begin
          cmd.push_children = status.room;
          state_next        = S_POP;
        end
      end
      S_CRD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_CLT;
      end
      S_CLT: begin
        cmd.latch    = LATCH_WORK;
        cmd.map_item = 1'b1;
        cmd.len_load = 1'b1;
        cmd.len_sel  = LEN_NODE;
        ap_sel_next  = MSEL_SUM;
        ret_next     = RET_CUR;
        state_next   = S_AP_GO;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    // A length write restarts the clearing pass.
    if (cfg_fire) begin
      cmd.clr_restart = 1'b1;
      state_next      = S_CLEAR;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      ap_sel    <= MSEL_SUM;
      ret       <= RET_LEFT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ap_sel    <= ap_sel_next;
      ret       <= ret_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_ready = (state == S_IDLE);

endmodule

FILE: sv/affine_range_update_sum_tree_unit.sv
// Top level of the affine range update / range sum lazy segment tree.
// Depends on arst_pkg, arst_ctrl and arst_datapath.
//
// Input items arrive on the s_axis channel: tuser selects a range sum query
// (0) or a range affine update x -> mul*x + add (1). A query delivers one item
// with the 64-bit wrapped sum on m_axis; an update delivers nothing.
// The cfg channel writes the number of elements in use (clamped to
// 1 .. MAX_LEN); each write zeroes the array and drops all pending maps.
// One item is processed at a time. Per item the walk time grows with each
// visited node, with each node whose pending map is pushed to its two
// children, with each covered node of an update and with each recombined
// node. It is set by the single-port node memory and the iterative
// multiplier, which forms each 64-bit product from 32 x 32 partial products.
// After reset, and after each cfg write, a clearing pass over all TREE_NODES
// nodes runs before s_axis_tready rises; cfg writes are taken at any time.
// A finished sum waits in the output register while the next item is
// accepted; a query that ends while that sum is still stalled holds until
// m_axis_tready frees it.
module affine_range_update_sum_tree_unit
  import arst_pkg::*;
#(
  parameter int unsigned MAX_LEN    = MAX_LEN_DEF,
  parameter int unsigned TREE_NODES = TREE_NODES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // range_left[9:0], range_right[19:10], mul_factor[83:20], add_term[147:84]
  input  logic [TDATA_W-1:0] s_axis_tdata,
  // func
  input  logic               s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // range_sum[63:0]
  output logic [OUT_W-1:0]   m_axis_tdata,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LEN_W-1:0]   cfg_data
);

  arst_cmd_t    cmd;
  arst_status_t status;
  logic         in_fire;
  logic         cfg_fire;

  assign cfg_ready = 1'b1;
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign cfg_fire  = cfg_valid && cfg_ready;

  arst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_fire  (cfg_fire),
    .in_fire   (in_fire),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid)
  );

  arst_datapath #(
    .MAX_LEN    (MAX_LEN),
    .TREE_NODES (TREE_NODES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .cfg_we   (cfg_fire),
    .cfg_data (cfg_data),
    .in_func  (s_axis_tuser),
    .in_left  (s_axis_tdata[9:0]),
    .in_right (s_axis_tdata[19:10]),
    .in_mul   (s_axis_tdata[83:20]),
    .in_add   (s_axis_tdata[147:84]),
    .out_data (m_axis_tdata)
  );

  // The block is busy on the cycle after it takes an item.
  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_axis_tready)
    else $error("input still ready after an item was taken");

  // A length write starts the clearing pass.
  a_clear_after_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_fire |=> !s_axis_tready)
    else $error("input ready right after a length write");

  // A sum appears only at the end of a walk.
  a_result_from_walk: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while idle");

endmodule

FILE: tb/tb_affine_range_update_sum_tree_unit.sv
// Self-checking testbench for affine_range_update_sum_tree_unit.
// Drives range updates and range sum queries, predicts the sums with a lazy
// segment tree of its own, and checks every result. Depends on arst_pkg.
`timescale 1ns / 100ps

module tb_affine_range_update_sum_tree_unit
  import arst_pkg::*;
();

  localparam int unsigned NODES      = 4096;
  localparam int unsigned LEN_MAX    = 1024;
  localparam int unsigned IDLE_WAIT  = 4000;
  localparam int unsigned WDOG_LIMIT = 60000;
  localparam int unsigned N_DIRECTED = 14;

  logic               clk;
  logic               rst;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata;
  logic               s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [OUT_W-1:0]   m_axis_tdata;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [LEN_W-1:0]   cfg_data;

  // One expected sum, with an optional hand-written value for directed rows.
  typedef struct {
    logic [63:0] sum;
    bit          typed;
    logic [63:0] typed_sum;
  } sum_exp_t;

  // One row of the directed stimulus table.
  typedef struct {
    logic        func;
    int unsigned left;
    int unsigned right;
    logic [63:0] mul;
    logic [63:0] add;
    bit          typed;
    logic [63:0] typed_sum;
  } op_row_t;

  // Shadow tree state.
  logic [63:0] seg_sum [NODES];
  logic [63:0] seg_mul [NODES];
  logic [63:0] seg_add [NODES];
  int unsigned elem_count;

  sum_exp_t    sum_queue[$];
  op_row_t     op_table[N_DIRECTED];
  int unsigned fail_count;
  int unsigned query_count;
  int unsigned update_count;
  int unsigned sums_checked;
  int unsigned idle_cycles;
  int unsigned out_stall;
  bit          idle_on;

  affine_range_update_sum_tree_unit i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Reset the shadow tree to zeros with identity maps.
  function automatic void clear_shadow();
    for (int i = 0; i < NODES; i++) begin
      seg_sum[i] = '0;
      seg_mul[i] = 64'd1;
      seg_add[i] = '0;
    end
  endfunction

  // Compose an affine map onto one node covering cnt elements.
  function automatic void map_node(int unsigned v, int unsigned cnt,
                                   logic [63:0] m, logic [63:0] a);
    if (v < NODES) begin
      seg_sum[v] = m * seg_sum[v] + a * 64'(cnt);
      seg_mul[v] = m * seg_mul[v];
      seg_add[v] = m * seg_add[v] + a;
    end
  endfunction

  // Hand the pending map of a node down to both children.
  function automatic void push_pending(int unsigned v, int unsigned lo, int unsigned hi);
    int unsigned cnt;
    if (lo < hi && 2 * v + 1 < NODES) begin
      cnt = hi - lo + 1;
      map_node(2 * v, (cnt + 1) / 2, seg_mul[v], seg_add[v]);
      map_node(2 * v + 1, cnt / 2, seg_mul[v], seg_add[v]);
      seg_mul[v] = 64'd1;
      seg_add[v] = '0;
    end
  endfunction

  // Walk the shadow tree; returns the sum over [ql, qr] for a query.
  function automatic logic [63:0] tree_walk(int unsigned v, int unsigned lo, int unsigned hi,
                                            bit upd, int unsigned ql, int unsigned qr,
                                            logic [63:0] m, logic [63:0] a);
    int unsigned mid;
    logic [63:0] acc;
    acc = '0;
    if (v == 0 || v >= NODES) return acc;
    push_pending(v, lo, hi);
    if (qr < lo || ql > hi) return acc;
    if (ql <= lo && hi <= qr) begin
      if (upd) map_node(v, hi - lo + 1, m, a);
      else acc = seg_sum[v];
      return acc;
    end
    mid = (lo + hi) / 2;
    acc = tree_walk(2 * v, lo, mid, upd, ql, qr, m, a)
        + tree_walk(2 * v + 1, mid + 1, hi, upd, ql, qr, m, a);
    if (upd && 2 * v + 1 < NODES) seg_sum[v] = seg_sum[2 * v] + seg_sum[2 * v + 1];
    return acc;
  endfunction

  // Print one mismatch line and count it.
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Send one operation item and record its expected sum when it is accepted.
  task automatic send_op(logic func, int unsigned l, int unsigned r,
                         logic [63:0] m, logic [63:0] a,
                         bit typed, logic [63:0] typed_sum);
    int unsigned gap;
    sum_exp_t    e;
    logic [63:0] s;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {4'b0, a, m, 10'(r), 10'(l)};
    do @(posedge clk); while (!s_axis_tready);
    s = tree_walk(1, 0, elem_count - 1, func == FUNC_UPDATE, l, r, m, a);
    if (func == FUNC_QUERY) begin
      e.sum = s;
      e.typed = typed;
      e.typed_sum = typed_sum;
      sum_queue.push_back(e);
      query_count++;
    end else begin
      update_count++;
    end
  endtask

  // Wait until every expected sum is in, then let an update drain.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sum_queue.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  // Write the element count while the block is idle.
  task automatic write_length(logic [LEN_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    elem_count = (value == 0) ? 1 : (value > LEN_MAX) ? LEN_MAX : value;
    clear_shadow();
  endtask

  // Random operation item, mostly inside the array.
  task automatic random_op();
    logic        func;
    int unsigned l, r, k;
    logic [63:0] m, a;
    func = 1'($urandom_range(0, 1));
    k = $urandom_range(0, 9);
    if (k < 7) begin
      l = $urandom_range(0, elem_count - 1);
      r = $urandom_range(l, elem_count - 1);
    end else if (k < 9) begin
      l = $urandom_range(0, 1023);
      r = $urandom_range(0, 1023);
    end else begin
      l = $urandom_range(1, 1023);
      r = $urandom_range(0, l - 1);
    end
    case ($urandom_range(0, 5))
      0: m = 64'd1;
      1: m = 64'd0;
      2: m = '1;
      3: m = 64'($urandom_range(0, 7));
      default: m = {$urandom, $urandom};
    endcase
    a = ($urandom_range(0, 2) == 0) ? 64'(signed'($urandom_range(0, 40)) - 20)
                                    : {$urandom, $urandom};
    send_op(func, l, r, m, a, 1'b0, '0);
  endtask

  // Result checker.
  always @(posedge clk) begin
    sum_exp_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (sum_queue.size() == 0) begin
        report_mismatch("unexpected range_sum", m_axis_tdata, '0);
      end else begin
        e = sum_queue.pop_front();
        sums_checked++;
        if (m_axis_tdata !== e.sum) report_mismatch("range_sum", m_axis_tdata, e.sum);
        if (e.typed && m_axis_tdata !== e.typed_sum)
          report_mismatch("range_sum (table)", m_axis_tdata, e.typed_sum);
      end
    end
  end

  // Receiver stalls: a random wait is drawn after each result while idle_on is set.
  always @(posedge clk) begin
    logic nxt;
    if (rst) begin
      out_stall <= 0;
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && idle_on) begin
        out_stall <= $urandom_range(0, 4);
        nxt = 1'b0;
      end else if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        nxt = 1'b0;
      end else begin
        nxt = 1'b1;
      end
      m_axis_tready <= nxt;
    end
  end

  // Watchdog on cycles without any handshake on s_axis, m_axis or cfg.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("affine_range_update_sum_tree_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main stimulus sequence.
  initial begin
    logic [LEN_W-1:0] phase_len[8];
    op_row_t          row;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_QUERY;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    fail_count = 0;
    query_count = 0;
    update_count = 0;
    sums_checked = 0;
    idle_on = 1'b1;
    elem_count = LEN_MAX;
    clear_shadow();
    // Directed rows: all zero after reset, set, add, wrap, empty range.
    op_table[0]  = '{FUNC_QUERY,  0, 1023, 0, 0, 1, 64'd0};
    op_table[1]  = '{FUNC_UPDATE, 0, 1023, 64'd0, 64'd5, 0, 0};
    op_table[2]  = '{FUNC_QUERY,  0, 1023, 0, 0, 1, 64'd5120};
    op_table[3]  = '{FUNC_QUERY,  9, 3, 0, 0, 1, 64'd0};
    op_table[4]  = '{FUNC_UPDATE, 9, 3, 64'd0, 64'd77, 0, 0};
    op_table[5]  = '{FUNC_QUERY,  1023, 1023, 0, 0, 1, 64'd5};
    op_table[6]  = '{FUNC_UPDATE, 100, 200, 64'd1, 64'd3, 0, 0};
    op_table[7]  = '{FUNC_QUERY,  150, 150, 0, 0, 1, 64'd8};
    op_table[8]  = '{FUNC_UPDATE, 0, 0, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0};
    op_table[9]  = '{FUNC_UPDATE, 1, 1, 64'd0, 64'h8000_0000_0000_0000, 0, 0};
    op_table[10] = '{FUNC_QUERY,  0, 1, 0, 0, 1, 64'hFFFF_FFFF_FFFF_FFFF};
    op_table[11] = '{FUNC_UPDATE, 0, 1023, '1, '1, 0, 0};
    op_table[12] = '{FUNC_QUERY,  0, 1023, '1, '1, 0, 0};
    op_table[13] = '{FUNC_QUERY,  37, 912, 0, 0, 0, 0};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = op_table[i];
      send_op(row.func, row.left, row.right, row.mul, row.add, row.typed, row.typed_sum);
    end

    // Register phases: clamp low, clamp high, small and large sizes.
    phase_len = '{11'd0, 11'd2047, 11'd37, 11'd1, 11'd5, 11'd700, 11'd1024, 11'd300};
    for (int p = 0; p < 8; p++) begin
      write_length(phase_len[p]);
      // Range past the end after a shrink.
      send_op(FUNC_UPDATE, 0, 1023, 64'd0, 64'd2, 1'b0, '0);
      send_op(FUNC_QUERY, 0, 1023, '0, '0, 1'b1, 64'(2 * elem_count));
      idle_on = (p % 3) != 2;
      for (int n = 0; n < 220; n++) begin
        if (n == 110) drain();
        random_op();
      end
    end

    drain();
    $display("covered %0d queries and %0d updates over 8 register settings",
             query_count, update_count);
    $display("%0d sums checked, %0d mismatches", sums_checked, fail_count);
    if (fail_count == 0 && sum_queue.size() == 0) begin
      $display("affine_range_update_sum_tree_unit verification clean");
    end else begin
      $display("%0d sums never arrived", sum_queue.size());
      $display("affine_range_update_sum_tree_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: affine_range_update_sum_tree_unit.f
sv/arst_pkg.sv
sv/arst_mul64.sv
sv/arst_datapath.sv
sv/arst_ctrl.sv
sv/affine_range_update_sum_tree_unit.sv
tb/tb_affine_range_update_sum_tree_unit.sv
